/* rtl/brd_pkg.sv */
package brd_pkg;

  localparam int unsigned MaxRegions     = 4;
  localparam int unsigned RegionsDefault = 4;
  localparam int unsigned AddrW          = 32;
  localparam int unsigned DataW          = 32;
  localparam int unsigned LanesW         = DataW / 8;
  localparam int unsigned KindW          = 3;
  localparam int unsigned SizeW          = 3;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KINDS    = 3'd4;

  // Window kinds; codes above KIND_DEV_RW count as empty
  localparam logic [KindW-1:0] KIND_EMPTY  = 3'd0;
  localparam logic [KindW-1:0] KIND_RAM    = 3'd1;
  localparam logic [KindW-1:0] KIND_ROM    = 3'd2;
  localparam logic [KindW-1:0] KIND_DEV_RD = 3'd3;
  localparam logic [KindW-1:0] KIND_DEV_WR = 3'd4;
  localparam logic [KindW-1:0] KIND_DEV_RW = 3'd5;

  // Access sizes in bytes
  localparam logic [SizeW-1:0] SIZE_BYTE = 3'd1;
  localparam logic [SizeW-1:0] SIZE_HALF = 3'd2;
  localparam logic [SizeW-1:0] SIZE_WORD = 3'd4;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_MEM    = 2'd0,
    STATUS_DEV    = 2'd1,
    STATUS_REJECT = 2'd2,
    STATUS_FAULT  = 2'd3
  } status_e;

  typedef struct packed {
    logic             command;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] access_bytes;
    logic [DataW-1:0] write_value;
    logic [DataW-1:0] fetched_word;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [1:0]        region_index;
    logic [AddrW-1:0]  region_offset;
    logic [LanesW-1:0] byte_enable;
    logic [DataW-1:0]  data;
    logic              fault_seen;
    logic [AddrW-1:0]  fault_location;
  } rsp_t;

endpackage

/* rtl/brd_chan_if.sv */
interface brd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/brd_decode.sv */
module brd_decode import brd_pkg::*; #(
  parameter int unsigned REGIONS = RegionsDefault
) (
  input  req_t                               req_i,
  input  logic [REGIONS-1:0][CfgDataW-1:0]   windows_i,
  input  logic [REGIONS-1:0][KindW-1:0]      kinds_i,
  input  logic                               fault_flag_i,
  input  logic [AddrW-1:0]                   fault_addr_i,
  output rsp_t                               rsp_o,
  output logic                               fault_set_o
);

  logic [REGIONS-1:0] hit;
  logic [REGIONS-1:0][AddrW-1:0] base;
  logic               size_ok;
  logic               found;
  logic [1:0]         idx;
  logic [KindW-1:0]   kind;
  logic [AddrW-1:0]   offset;
  logic [LanesW-1:0]  size_lanes;
  logic [LanesW-1:0]  lanes;
  logic [4:0]         shamt;
  logic [DataW-1:0]   wval_sh;
  logic [DataW-1:0]   rd_mask;
  logic [DataW-1:0]   merged;
  logic [AddrW:0]     acc_end;

  assign acc_end = {1'b0, req_i.address} + (AddrW+1)'(req_i.access_bytes);

  // Size and natural alignment
  always_comb begin
    size_ok    = 1'b0;
    size_lanes = '0;
    case (req_i.access_bytes)
      SIZE_BYTE: begin
        size_ok    = 1'b1;
        size_lanes = 4'b0001;
      end
      SIZE_HALF: begin
        size_ok    = ~req_i.address[0];
        size_lanes = 4'b0011;
      end
      SIZE_WORD: begin
        size_ok    = (req_i.address[1:0] == 2'b00);
        size_lanes = 4'b1111;
      end
      default: begin
        size_ok    = 1'b0;
        size_lanes = '0;
      end
    endcase
  end

  // Window compares run side by side
  for (genvar g = 0; g < REGIONS; g++) begin : g_win
    logic [AddrW:0] lim;
    logic           live;
    assign base[g] = {windows_i[g][AddrW-1:2], 2'b00};
    assign lim     = {1'b0, base[g]} + {1'b0, windows_i[g][CfgDataW-1:AddrW]};
    assign live    = (kinds_i[g] != KIND_EMPTY) && (kinds_i[g] <= KIND_DEV_RW);
    assign hit[g]  = live && (req_i.address >= base[g]) && (acc_end <= lim);
  end

  // Lowest matching window wins
  always_comb begin
    found  = 1'b0;
    idx    = '0;
    kind   = KIND_EMPTY;
    offset = '0;
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found  = 1'b1;
        idx    = 2'(i);
        kind   = kinds_i[i];
        offset = req_i.address - base[i];
      end
    end
  end

  assign shamt   = {req_i.address[1:0], 3'b000};
  assign lanes   = size_lanes << req_i.address[1:0];
  assign wval_sh = req_i.write_value << shamt;

  always_comb begin
    for (int b = 0; b < LanesW; b++) begin
      rd_mask[8*b +: 8] = {8{size_lanes[b]}};
      merged[8*b +: 8]  = lanes[b] ? wval_sh[8*b +: 8] : req_i.fetched_word[8*b +: 8];
    end
  end

  always_comb begin
    rsp_o       = '0;
    fault_set_o = 1'b0;
    if (!size_ok) begin
      rsp_o.status = STATUS_REJECT;
    end else if (!found) begin
      fault_set_o = 1'b1;
    end else begin
      rsp_o.region_index  = idx;
      rsp_o.region_offset = offset;
      if (kind == KIND_RAM || kind == KIND_ROM) begin
        if (req_i.command == CMD_READ) begin
          rsp_o.status      = STATUS_MEM;
          rsp_o.byte_enable = lanes;
          rsp_o.data        = (req_i.fetched_word >> shamt) & rd_mask;
        end else if (kind == KIND_RAM) begin
          rsp_o.status      = STATUS_MEM;
          rsp_o.byte_enable = lanes;
          rsp_o.data        = merged;
        end else begin
          fault_set_o = 1'b1;
        end
      end else if (req_i.command == CMD_WRITE) begin
        if (kind == KIND_DEV_WR || kind == KIND_DEV_RW) begin
          rsp_o.status      = STATUS_DEV;
          rsp_o.byte_enable = lanes;
          rsp_o.data        = req_i.write_value;
        end else begin
          fault_set_o = 1'b1;
        end
      end else begin
        if (kind == KIND_DEV_RD || kind == KIND_DEV_RW) begin
          rsp_o.status      = STATUS_DEV;
          rsp_o.byte_enable = lanes;
        end else begin
          fault_set_o = 1'b1;
        end
      end
    end
    if (fault_set_o) begin
      rsp_o.status      = STATUS_FAULT;
      rsp_o.byte_enable = '0;
      rsp_o.data        = '0;
    end
    rsp_o.fault_seen     = fault_set_o | fault_flag_i;
    rsp_o.fault_location = fault_set_o ? req_i.address : fault_addr_i;
  end

endmodule

/* rtl/bus_region_decoder.sv */
// Bus region decoder: an accepted transaction passes through the input register,
// the combinational decode stage and then the result register, which offers it.
// Throughput is one transaction per cycle while the response sink keeps taking
// results; the window compares of all regions run in parallel in the single
// decode stage between the two registers.
// Reset clears both pipeline valids, the window, kind and sticky fault registers.
module bus_region_decoder import brd_pkg::*; #(
  parameter int unsigned REGIONS = RegionsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  brd_chan_if.sink            req_i,
  brd_chan_if.source          rsp_o
);

  // Configuration registers
  logic [REGIONS-1:0][CfgDataW-1:0] windows_q;
  logic [REGIONS-1:0][KindW-1:0]    kinds_q;

  // Sticky fault state
  logic             fault_flag_q;
  logic [AddrW-1:0] fault_addr_q;

  // Input register
  logic s1_valid_q;
  req_t s1_req_q;

  // Result register
  logic s2_valid_q;
  rsp_t s2_rsp_q;

  logic s1_advance;
  rsp_t dec_rsp;
  logic dec_fault;

  // One window register per configured region; writes to absent regions drop.
  for (genvar g = 0; g < REGIONS; g++) begin : g_cfg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        windows_q[g] <= '0;
      end else if (cfg_we_i && cfg_index_i == CFG_WINDOW_0 + CfgIdxW'(g)) begin
        windows_q[g] <= cfg_data_i;
      end
    end
  end

  // Kind fields are packed three bits per region.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kinds_q <= '0;
    end else if (cfg_we_i && cfg_index_i == CFG_KINDS) begin
      kinds_q <= cfg_data_i[KindW*REGIONS-1:0];
    end
  end

  // The decode stage moves on when the result register is empty or draining.
  assign s1_advance = !s2_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_req_q <= req_i.payload;
    end
  end

  brd_decode #(
    .REGIONS (REGIONS)
  ) u_decode (
    .req_i        (s1_req_q),
    .windows_i    (windows_q),
    .kinds_i      (kinds_q),
    .fault_flag_i (fault_flag_q),
    .fault_addr_i (fault_addr_q),
    .rsp_o        (dec_rsp),
    .fault_set_o  (dec_fault)
  );

  // Update the fault state only as the transaction leaves decode, so
  // transactions see it strictly in order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_flag_q <= 1'b0;
      fault_addr_q <= '0;
    end else if (s1_valid_q && s1_advance && dec_fault) begin
      fault_flag_q <= 1'b1;
      fault_addr_q <= s1_req_q.address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Hold the result while the sink stalls.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_advance) begin
      s2_rsp_q <= dec_rsp;
    end
  end

  assign rsp_o.valid   = s2_valid_q;
  assign rsp_o.payload = s2_rsp_q;

endmodule

/* tb/tb_bus_region_decoder.sv */
module tb_bus_region_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import brd_pkg::*;

  // Clock, reset and configuration port
  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // Request and response channels
  brd_chan_if #(.payload_t(req_t)) req_if ();
  brd_chan_if #(.payload_t(rsp_t)) rsp_if ();

  bus_region_decoder #(
    .REGIONS(RegionsDefault)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Shadow copy of the address map, updated whenever the map is programmed
  logic [63:0] win_cfg [MaxRegions];
  logic [11:0] kinds_cfg;

  // Shadow copy of the sticky fault state
  logic        pred_fault_flag;
  logic [31:0] pred_fault_addr;

  // Accesses waiting for the driver, and decodes waiting for the DUT
  req_t        pending_accesses [$];
  rsp_t        predicted_decodes [$];
  int unsigned accesses_queued;
  int unsigned results_seen;
  int unsigned mismatches;

  // Idle controls: per-side random gaps, plus the long response hold-off
  logic        req_idle_on;
  logic        rsp_idle_on;
  logic        hold_go;
  int unsigned hold_left;
  int unsigned req_gap;
  int unsigned rsp_wait;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous upper bound on the whole run
  initial begin
    #5_000_000;
    $display("tb_bus_region_decoder NOT OK");
    $finish;
  end

  // Print one line per mismatch and count every one of them.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatches++;
  endtask

  // Draw the number of idle cycles before the next transaction on one side.
  // At least half of the draws are zero so back-to-back traffic stays common.
  function automatic int unsigned draw_gap(input logic enabled);
    if (!enabled) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Decode one access against the shadow map and advance the shadow fault state.
  function automatic rsp_t decode_access(input req_t acc);
    rsp_t        res;
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] mask;
    logic [32:0] acc_end;
    logic [2:0]  kind;
    logic [2:0]  hit_kind;
    logic [3:0]  lanes;
    logic [4:0]  shift;
    logic [1:0]  align;
    logic        size_ok;
    logic        hit;
    logic        allowed;

    res      = '0;
    hit      = 1'b0;
    hit_kind = KIND_EMPTY;
    size_ok  = 1'b1;
    case (acc.access_bytes)
      SIZE_BYTE: begin
        align = 2'b00; lanes = 4'b0001; mask = 32'h0000_00FF;
      end
      SIZE_HALF: begin
        align = 2'b01; lanes = 4'b0011; mask = 32'h0000_FFFF;
      end
      SIZE_WORD: begin
        align = 2'b11; lanes = 4'b1111; mask = 32'hFFFF_FFFF;
      end
      default: begin
        align = 2'b11; lanes = 4'b0000; mask = 32'h0; size_ok = 1'b0;
      end
    endcase

    if (!size_ok || (acc.address[1:0] & align) != 2'b00) begin
      // Bad size or misaligned: reject, leave the fault state alone
      res.status = STATUS_REJECT;
    end else begin
      acc_end = {1'b0, acc.address} + 33'(acc.access_bytes);
      // First non-empty window that holds every byte wins; the end is
      // compared on 33 bits so windows running past the top just clip.
      for (int i = 0; i < MaxRegions; i++) begin
        kind = kinds_cfg[3*i +: 3];
        base = {win_cfg[i][31:2], 2'b00};
        size = win_cfg[i][63:32];
        if (!hit && kind != KIND_EMPTY && kind <= KIND_DEV_RW &&
            acc.address >= base && acc_end <= ({1'b0, base} + {1'b0, size})) begin
          hit               = 1'b1;
          hit_kind          = kind;
          res.region_index  = 2'(i);
          res.region_offset = acc.address - base;
        end
      end

      lanes = lanes << acc.address[1:0];
      shift = {acc.address[1:0], 3'b000};
      if (!hit) begin
        res.status = STATUS_FAULT;
      end else if (hit_kind == KIND_RAM || hit_kind == KIND_ROM) begin
        if (acc.command == CMD_READ) begin
          res.status      = STATUS_MEM;
          res.byte_enable = lanes;
          res.data        = (acc.fetched_word >> shift) & mask;
        end else if (hit_kind == KIND_RAM) begin
          res.status      = STATUS_MEM;
          res.byte_enable = lanes;
          res.data        = (acc.fetched_word & ~(mask << shift)) |
                            ((acc.write_value & mask) << shift);
        end else begin
          res.status = STATUS_FAULT;
        end
      end else begin
        allowed = (acc.command == CMD_WRITE) ?
                  (hit_kind == KIND_DEV_WR || hit_kind == KIND_DEV_RW) :
                  (hit_kind == KIND_DEV_RD || hit_kind == KIND_DEV_RW);
        if (allowed) begin
          res.status      = STATUS_DEV;
          res.byte_enable = lanes;
          res.data        = (acc.command == CMD_WRITE) ? acc.write_value : 32'h0;
        end else begin
          res.status = STATUS_FAULT;
        end
      end

      if (res.status == STATUS_FAULT) begin
        pred_fault_flag = 1'b1;
        pred_fault_addr = acc.address;
      end
    end

    res.fault_seen     = pred_fault_flag;
    res.fault_location = pred_fault_addr;
    return res;
  endfunction

  // Random window: bases cluster in a few areas so windows overlap and
  // shadow each other; sizes are mostly small, sometimes zero or huge.
  function automatic logic [63:0] rand_window();
    logic [31:0] base;
    logic [31:0] size;
    int unsigned pick;

    pick = $urandom_range(0, 3);
    case (pick)
      0:       base = $urandom_range(0, 32'h3000);
      1:       base = 32'h2000_0000 + $urandom_range(0, 32'h3000);
      2:       base = 32'hFFFF_C000 + $urandom_range(0, 32'h3FFF);
      default: base = $urandom;
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 5)       size = $urandom_range(1, 256);
    else if (pick < 8)  size = $urandom_range(1, 32'h2000);
    else if (pick == 8) size = 32'h0;
    else                size = $urandom;
    return {size, base};
  endfunction

  // Random access aimed mostly inside or at the edges of a programmed window,
  // mostly well-formed, with some bad sizes, misalignment and wild addresses.
  function automatic req_t rand_access();
    req_t        acc;
    logic [31:0] base;
    logic [31:0] size;
    int unsigned pick;
    int unsigned w;

    w    = $urandom_range(0, MaxRegions - 1);
    base = {win_cfg[w][31:2], 2'b00};
    size = win_cfg[w][63:32];
    pick = $urandom_range(0, 99);
    if (pick < 55)      acc.address = base + ((size == 0) ? 32'h0 : $urandom_range(0, size - 1));
    else if (pick < 70) acc.address = base + size - $urandom_range(0, 8);
    else if (pick < 80) acc.address = base - $urandom_range(0, 8);
    else                acc.address = $urandom;

    pick = $urandom_range(0, 99);
    if (pick < 30)      acc.access_bytes = SIZE_BYTE;
    else if (pick < 55) acc.access_bytes = SIZE_HALF;
    else if (pick < 85) acc.access_bytes = SIZE_WORD;
    else                acc.access_bytes = 3'($urandom_range(0, 7));

    if ($urandom_range(0, 99) < 85) begin
      if (acc.access_bytes == SIZE_HALF) acc.address[0] = 1'b0;
      if (acc.access_bytes == SIZE_WORD) acc.address[1:0] = 2'b00;
    end
    acc.command      = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE;
    acc.write_value  = $urandom;
    acc.fetched_word = $urandom;
    return acc;
  endfunction

  // Append one access to the driver's queue.
  task automatic queue_access(input logic cmd, input logic [31:0] addr,
                              input logic [SizeW-1:0] nbytes,
                              input logic [31:0] wval, input logic [31:0] word);
    req_t acc;
    acc.command      = cmd;
    acc.address      = addr;
    acc.access_bytes = nbytes;
    acc.write_value  = wval;
    acc.fetched_word = word;
    pending_accesses.push_back(acc);
    accesses_queued++;
  endtask

  // Program all four windows and the kind register, one write per cycle,
  // and mirror them in the shadow map.
  task automatic program_map(input logic [63:0] w0, input logic [63:0] w1,
                             input logic [63:0] w2, input logic [63:0] w3,
                             input logic [11:0] kinds);
    logic [63:0] vals [5];
    vals = '{w0, w1, w2, w3, {52'd0, kinds}};
    for (int r = 0; r < 5; r++) begin
      @(posedge clk_i);
      cfg_we    <= 1'b1;
      cfg_index <= (r == 4) ? CFG_KINDS : CFG_WINDOW_0 + CfgIdxW'(r);
      cfg_data  <= vals[r];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    for (int r = 0; r < MaxRegions; r++) win_cfg[r] = vals[r];
    kinds_cfg = kinds;
  endtask

  // Wait until every queued access has produced its result, then let the
  // two pipeline stages settle before touching the configuration.
  task automatic wait_drained();
    while (results_seen != accesses_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Long response hold-off, counted here so the sender keeps pushing while
  // the DUT fills up and drops its request ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Request driver: predict on every accepted transaction, then either
  // hold the slot idle for the drawn gap or present the next pending access.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      req_gap        <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predicted_decodes.push_back(decode_access(req_if.payload));
      end
      // Slot is free when nothing is offered or the offer was just taken
      if (!req_if.valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_gap      <= req_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_accesses.size() != 0) begin
          req_if.payload <= pending_accesses.pop_front();
          req_if.valid   <= 1'b1;
          req_gap        <= draw_gap(req_idle_on);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compare each accepted result with the oldest
  // prediction, field by field, then draw how long to stall the next one.
  always @(posedge clk_i) begin : result_monitor
    int unsigned stall;
    rsp_t        want;
    rsp_t        got;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_wait     <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        results_seen++;
        if (predicted_decodes.size() == 0) begin
          report_mismatch("result with no transaction pending", got.region_offset, 32'h0);
        end else begin
          want = predicted_decodes.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.region_index != want.region_index)
            report_mismatch("region_index", 32'(got.region_index), 32'(want.region_index));
          if (got.region_offset != want.region_offset)
            report_mismatch("region_offset", got.region_offset, want.region_offset);
          if (got.byte_enable != want.byte_enable)
            report_mismatch("byte_enable", 32'(got.byte_enable), 32'(want.byte_enable));
          if (got.data != want.data)
            report_mismatch("data", got.data, want.data);
          if (got.fault_seen != want.fault_seen)
            report_mismatch("fault_seen", 32'(got.fault_seen), 32'(want.fault_seen));
          if (got.fault_location != want.fault_location)
            report_mismatch("fault_location", got.fault_location, want.fault_location);
        end
        stall        = draw_gap(rsp_idle_on);
        rsp_wait     <= stall;
        rsp_if.ready <= (stall == 0) && (hold_left == 0);
      end else if (rsp_wait != 0) begin
        rsp_wait     <= rsp_wait - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= (hold_left == 0);
      end
    end
  end

  // Stimulus: reset, directed accesses under three maps, then random phases.
  initial begin
    logic [11:0] kinds;
    req_t        acc;

    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    hold_go         = 1'b0;
    req_idle_on     = 1'b0;
    rsp_idle_on     = 1'b0;
    pred_fault_flag = 1'b0;
    pred_fault_addr = 32'h0;
    kinds_cfg       = 12'h0;
    accesses_queued = 0;
    results_seen    = 0;
    mismatches      = 0;
    for (int r = 0; r < MaxRegions; r++) win_cfg[r] = 64'h0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Map at reset is all empty: any good access faults, a bad size rejects
    queue_access(CMD_READ, 32'h0000_0000, SIZE_WORD, 32'h0, 32'hFFFF_FFFF);
    queue_access(CMD_WRITE, 32'h1234_5678, 3'd3, 32'hFFFF_FFFF, 32'h0);
    wait_drained();

    // Typical map: ram, rom with a misaligned base, rw device, read-only device
    program_map({32'h0000_1000, 32'h2000_0000}, {32'h0000_0800, 32'h0800_0002},
                {32'h0000_0400, 32'h4000_0000}, {32'h0000_0010, 32'h5000_0000},
                {KIND_DEV_RD, KIND_DEV_RW, KIND_ROM, KIND_RAM});
    // Byte reads on every lane
    for (int l = 0; l < 4; l++) begin
      queue_access(CMD_READ, 32'h2000_0000 + l, SIZE_BYTE, 32'h0, 32'h8899_AABB);
    end
    queue_access(CMD_WRITE, 32'h2000_0002, SIZE_HALF, 32'hDEAD_BEEF, 32'h1122_3344);
    // Last word of ram, then the byte just past its end
    queue_access(CMD_WRITE, 32'h2000_0FFC, SIZE_WORD, 32'hFFFF_FFFF, 32'h0);
    queue_access(CMD_READ, 32'h2000_0FFE, SIZE_HALF, 32'h0, 32'hCAFE_F00D);
    queue_access(CMD_READ, 32'h2000_1000, SIZE_BYTE, 32'h0, 32'h0);
    // Rom read is fine, rom write faults
    queue_access(CMD_READ, 32'h0800_0000, SIZE_WORD, 32'h0, 32'h0BAD_CAFE);
    queue_access(CMD_WRITE, 32'h0800_0001, SIZE_BYTE, 32'hA5, 32'h0);
    // Devices: both directions on rw, write to read-only faults
    queue_access(CMD_READ, 32'h4000_0010, SIZE_WORD, 32'h1357_9BDF, 32'h0);
    queue_access(CMD_WRITE, 32'h4000_03FC, SIZE_WORD, 32'h2468_ACE0, 32'h0);
    queue_access(CMD_READ, 32'h5000_000C, SIZE_WORD, 32'h0, 32'h0);
    queue_access(CMD_WRITE, 32'h5000_0000, SIZE_BYTE, 32'h5A, 32'h0);
    // Bad sizes and misalignment are rejected without touching the fault state
    queue_access(CMD_READ, 32'h2000_0000, 3'd3, 32'h0, 32'h0);
    queue_access(CMD_READ, 32'h2000_0000, 3'd0, 32'h0, 32'h0);
    queue_access(CMD_WRITE, 32'h2000_0000, 3'd7, 32'h0, 32'h0);
    queue_access(CMD_READ, 32'h2000_0001, SIZE_HALF, 32'h0, 32'h0);
    queue_access(CMD_WRITE, 32'h2000_0002, SIZE_WORD, 32'h0, 32'h0);
    wait_drained();

    // Extreme map: all-ones window that runs past the top, zero-size ram,
    // a kind code above the device range, and a tiny rom at address zero
    program_map(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, {32'hFFFF_FFFF, 32'h0},
                {32'h0000_0004, 32'h0000_0000},
                {KIND_ROM, 3'd6, KIND_RAM, KIND_DEV_WR});
    queue_access(CMD_WRITE, 32'hFFFF_FFFC, SIZE_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_access(CMD_READ, 32'hFFFF_FFFF, SIZE_BYTE, 32'h0, 32'hFFFF_FFFF);
    queue_access(CMD_WRITE, 32'hFFFF_FFFF, SIZE_BYTE, 32'h0000_00FF, 32'h0);
    queue_access(CMD_READ, 32'h0000_0000, SIZE_WORD, 32'h0, 32'hFFFF_FFFF);
    queue_access(CMD_WRITE, 32'h0000_0002, SIZE_HALF, 32'hFFFF, 32'h0);
    queue_access(CMD_READ, 32'h0000_0010, SIZE_BYTE, 32'h0, 32'h0);
    wait_drained();

    // Random phases: a fresh map each time and an idling pattern set per phase
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < MaxRegions; r++) begin
        // Mostly live kinds, sometimes empty or an unused code
        if ($urandom_range(0, 99) < 85) kinds[3*r +: 3] = 3'($urandom_range(1, 5));
        else kinds[3*r +: 3] = 3'($urandom_range(0, 7));
      end
      program_map(rand_window(), rand_window(), rand_window(), rand_window(), kinds);
      @(posedge clk_i);
      req_idle_on <= (ph == 1 || ph == 3 || ph == 5);
      rsp_idle_on <= (ph == 2 || ph == 3 || ph == 5);
      // In one phase, stop draining responses for a long stretch while the
      // sender keeps offering back-to-back
      hold_go <= (ph == 4);
      @(posedge clk_i);
      hold_go <= 1'b0;
      for (int n = 0; n < 118; n++) begin
        acc = rand_access();
        queue_access(acc.command, acc.address, acc.access_bytes,
                     acc.write_value, acc.fetched_word);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (predicted_decodes.size() != 0) begin
      report_mismatch("results never delivered", predicted_decodes.size(), 32'h0);
    end
    if (mismatches == 0) begin
      $display("tb_bus_region_decoder OK");
    end else begin
      $display("tb_bus_region_decoder NOT OK");
    end
    $finish;
  end

endmodule
